// ----- rtl/kpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// kpsd_pkg
// Shared constants and helper functions for the keypad scan and debounce block.
// ----------------------------------------------------------------------------
package kpsd_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CMP_WIDTH   = 32;

   localparam int unsigned TICKS_WIDTH = 16;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [15:0] DEBOUNCE_TICKS_RESET = 16'd16;

   // register index, taken from paddr[2]
   localparam logic REG_DEBOUNCE_TICKS = 1'b0;

   localparam logic [3:0] ROW_CODE_MAX = 4'd4;

   // weighted row sum: row1*1 + row2*2 + row3*3 + row4*4
   function automatic logic [3:0] row_code(input logic [3:0] rows);
      logic [3:0] sum;
      begin
         sum = 4'd0;
         if (rows[0]) sum = sum + 4'd1;
         if (rows[1]) sum = sum + 4'd2;
         if (rows[2]) sum = sum + 4'd3;
         if (rows[3]) sum = sum + 4'd4;
         return sum;
      end
   endfunction

   // key code from row code (1..4) and column index (modulo 3)
   function automatic logic [3:0] key_lookup(input logic [3:0] code, input logic [1:0] col);
      logic [1:0] c;
      logic [3:0] k;
      begin
         c = (col == 2'd3) ? 2'd0 : col;
         k = 4'd0;
         case (code)
            4'd1: begin
               case (c)
                  2'd0:    k = 4'd1;
                  2'd1:    k = 4'd2;
                  default: k = 4'd3;
               endcase
            end
            4'd2: begin
               case (c)
                  2'd0:    k = 4'd4;
                  2'd1:    k = 4'd5;
                  default: k = 4'd6;
               endcase
            end
            4'd3: begin
               case (c)
                  2'd0:    k = 4'd7;
                  2'd1:    k = 4'd8;
                  default: k = 4'd9;
               endcase
            end
            4'd4: begin
               case (c)
                  2'd0:    k = 4'd10;
                  2'd1:    k = 4'd0;
                  default: k = 4'd11;
               endcase
            end
            default: k = 4'd0;
         endcase
         return k;
      end
   endfunction

endpackage

// ----- rtl/keypad_scan_debounce.sv -----
// ----------------------------------------------------------------------------
// keypad_scan_debounce
// Scanner and debouncer for a 3-column by 4-row keypad, one step per transfer.
// ----------------------------------------------------------------------------
// Each request transfer carries the sampled row lines and a tick strobe and
// produces exactly one response transfer with the column drive, the captured
// key and status. The scan state machine and the saturating debounce counter
// compare sit between the request port and a single response register, so a
// new request is taken every cycle unless the response register is full and
// stalled. The debounce wait length is set by the debounce_ticks register at
// byte address 0 (reset value 16); write it only while no transfer is in
// flight. Presses whose weighted row code exceeds 4 at confirmation raise
// several_rows and capture nothing.
module keypad_scan_debounce (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [3:0]                      req_row_lines,
   input  logic                            req_tick,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_column_drive,
   output logic                            rsp_key_valid,
   output logic [3:0]                      rsp_key_code,
   output logic [3:0]                      rsp_last_key,
   output logic                            rsp_several_rows,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [kpsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [kpsd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [kpsd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   typedef enum logic [2:0] {
      SCAN_COL1     = 3'd0,
      SCAN_COL2     = 3'd1,
      SCAN_COL3     = 3'd2,
      PRESS_WAIT    = 3'd3,
      PRESS_CHECK   = 3'd4,
      HELD          = 3'd5,
      RELEASE_WAIT  = 3'd6,
      RELEASE_CHECK = 3'd7
   } scan_state_type;

   localparam logic [kpsd_pkg::COUNT_WIDTH-1:0] CountMax = '1;

   scan_state_type                      state_ff, state_in;
   logic [1:0]                          col_idx_ff, col_idx_in;
   logic [2:0]                          column_ff, column_in;
   logic [kpsd_pkg::COUNT_WIDTH-1:0]    count_ff, count_in, count_inc;
   logic [3:0]                          held_ff, held_in;
   logic [kpsd_pkg::TICKS_WIDTH-1:0]    ticks_ff;

   logic                                rsp_valid_ff;
   logic [2:0]                          out_column_ff;
   logic                                out_key_valid_ff, out_key_valid_in;
   logic [3:0]                          out_key_code_ff, out_key_code_in;
   logic [3:0]                          out_last_key_ff;
   logic                                out_several_ff, out_several_in;

   logic                                req_take;
   logic                                csr_write;
   logic [3:0]                          code;
   logic                                wait_done;

   // ---- configuration ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == kpsd_pkg::REG_DEBOUNCE_TICKS)
                       ? kpsd_pkg::CSR_DATA_W'(ticks_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= kpsd_pkg::DEBOUNCE_TICKS_RESET;
      end else if (csr_write && csr_paddr[2] == kpsd_pkg::REG_DEBOUNCE_TICKS) begin
         ticks_ff <= csr_pwdata[kpsd_pkg::TICKS_WIDTH-1:0];
      end
   end

   // ---- handshake ----
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   // ---- step logic ----
   assign code      = kpsd_pkg::row_code(req_row_lines);
   assign count_inc = (req_tick && count_ff != CountMax) ? count_ff + 1'b1 : count_ff;
   assign wait_done = (kpsd_pkg::CMP_WIDTH'(count_inc) >= kpsd_pkg::CMP_WIDTH'(ticks_ff))
                      || (count_inc == CountMax);

   always_comb begin
      state_in         = state_ff;
      col_idx_in       = col_idx_ff;
      column_in        = column_ff;
      count_in         = count_inc;
      held_in          = held_ff;
      out_key_valid_in = 1'b0;
      out_key_code_in  = 4'd0;
      out_several_in   = 1'b0;
      case (state_ff)
         SCAN_COL1, SCAN_COL2, SCAN_COL3: begin
            if (code == 4'd0) begin
               case (state_ff)
                  SCAN_COL1: begin
                     col_idx_in = 2'd0;
                     column_in  = 3'b001;
                     state_in   = SCAN_COL2;
                  end
                  SCAN_COL2: begin
                     col_idx_in = 2'd1;
                     column_in  = 3'b010;
                     state_in   = SCAN_COL3;
                  end
                  default: begin
                     col_idx_in = 2'd2;
                     column_in  = 3'b100;
                     state_in   = SCAN_COL1;
                  end
               endcase
            end else begin
               count_in = '0;
               state_in = PRESS_WAIT;
            end
         end
         PRESS_WAIT: begin
            if (wait_done) state_in = PRESS_CHECK;
         end
         PRESS_CHECK: begin
            if (code == 4'd0) begin
               state_in = SCAN_COL2;
            end else begin
               if (code <= kpsd_pkg::ROW_CODE_MAX) begin
                  held_in          = kpsd_pkg::key_lookup(code, col_idx_ff);
                  out_key_code_in  = held_in;
                  out_key_valid_in = 1'b1;
               end else begin
                  out_several_in = 1'b1;
               end
               state_in = HELD;
            end
         end
         HELD: begin
            if (code == 4'd0) begin
               count_in = '0;
               state_in = RELEASE_WAIT;
            end
         end
         RELEASE_WAIT: begin
            if (wait_done) state_in = RELEASE_CHECK;
         end
         RELEASE_CHECK: begin
            state_in = (code != 4'd0) ? HELD : SCAN_COL1;
         end
         default: state_in = SCAN_COL1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SCAN_COL1;
         col_idx_ff <= 2'd0;
         column_ff  <= 3'b000;
         count_ff   <= '0;
         held_ff    <= 4'd0;
      end else if (req_take) begin
         state_ff   <= state_in;
         col_idx_ff <= col_idx_in;
         column_ff  <= column_in;
         count_ff   <= count_in;
         held_ff    <= held_in;
      end
   end

   // ---- response register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         out_column_ff    <= column_in;
         out_key_valid_ff <= out_key_valid_in;
         out_key_code_ff  <= out_key_code_in;
         out_last_key_ff  <= held_in;
         out_several_ff   <= out_several_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column_drive = out_column_ff;
   assign rsp_key_valid    = out_key_valid_ff;
   assign rsp_key_code     = out_key_code_ff;
   assign rsp_last_key     = out_last_key_ff;
   assign rsp_several_rows = out_several_ff;

   // ---- assertions ----
   a_take_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted request did not load the response register");

   a_key_or_several: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_key_valid_ff && out_several_ff))
      else $error("key capture and several_rows flagged together");

   a_no_key_zero_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_key_valid_ff) |-> (out_key_code_ff == 4'd0))
      else $error("key_code nonzero without a capture");

   a_column_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(column_ff))
      else $error("column drive not one-hot");

   a_capture_sets_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_key_valid_ff) |-> (out_last_key_ff == out_key_code_ff))
      else $error("last_key does not follow the captured key");

endmodule
